[rtl/core/hmp_pkg.sv]
// Shared types and constants for the hash message padder.
// Used by hmp_ctrl, hmp_datapath and hash_message_padder; no dependencies.
package hmp_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;
  localparam int unsigned COUNT_W    = 61;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MODE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_BIG_ENDIAN = 1'd1;

  localparam logic [7:0] PAD_MARKER = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [63:0] block_word;
    logic        block_end;
    logic        message_end;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD_HEAD,
    ST_PAD_BODY
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;      // input transfer this cycle
    logic pad_head;  // emit partial word with 0x80 marker
    logic pad_zero;  // emit all-zero padding word
    logic pad_len;   // emit bit-length word, close message
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register can load this cycle
    logic at_len;    // current word slot is the length slot of the block
  } dp_status_t;

endpackage

[rtl/core/hmp_ctrl.sv]
// Sequencer for the hash message padder: byte intake and padding burst.
// Depends on hmp_pkg.
module hmp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_eom,
  output logic               in_stall,
  input  hmp_pkg::dp_status_t sts,
  output hmp_pkg::ctl_cmd_t  cmd
);
  import hmp_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = !((state_r == ST_IDLE) && sts.out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_eom) state_nxt = ST_PAD_HEAD;
      end
      ST_PAD_HEAD: begin
        if (sts.out_free) state_nxt = ST_PAD_BODY;
      end
      ST_PAD_BODY: begin
        if (sts.out_free && sts.at_len) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:     cmd.take     = accept;
      ST_PAD_HEAD: cmd.pad_head = sts.out_free;
      ST_PAD_BODY: begin
        cmd.pad_zero = sts.out_free && !sts.at_len;
        cmd.pad_len  = sts.out_free && sts.at_len;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/hmp_datapath.sv]
// Word packing, block position, byte counter and output register.
// Depends on hmp_pkg.
module hmp_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                block_mode,
  input  logic                len_big_endian,
  input  hmp_pkg::in_item_t   in_data,
  input  hmp_pkg::ctl_cmd_t   cmd,
  output hmp_pkg::dp_status_t sts,
  output logic                out_valid,
  input  logic                out_stall,
  output hmp_pkg::out_item_t  out_data
);
  import hmp_pkg::*;

  logic [COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [55:0]        word_buf_r, word_buf_nxt;
  logic [6:0]         pos_r, pos_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic [7:0]  blk_bytes, len_slot;
  logic [7:0]  pos_inc, word_start, word_end;
  logic [2:0]  fill;
  logic [6:0]  head_sh;
  logic [63:0] head_word, bits_be, bits_le;
  logic        byte_bend, pad_bend;

  assign blk_bytes  = block_mode ? 8'd128 : 8'd64;
  assign len_slot   = blk_bytes - 8'd8;
  assign fill       = pos_r[2:0];
  assign word_start = {1'b0, pos_r[6:3], 3'b000};
  assign word_end   = word_start + 8'd8;
  assign pos_inc    = {1'b0, pos_r} + 8'd1;
  assign byte_bend  = pos_inc >= blk_bytes;
  assign pad_bend   = word_end >= blk_bytes;

  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.at_len   = word_start == len_slot;

  // left-align the partial word; an empty buffer shifts out entirely
  assign head_sh   = {4'd8 - {1'b0, fill}, 3'b000};
  assign head_word = ({8'h00, word_buf_r} << head_sh)
                   | ({PAD_MARKER, 56'h0} >> {fill, 3'b000});

  assign bits_be = {byte_count_r, 3'b000};
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bits_le[8*i +: 8] = bits_be[56-8*i +: 8];
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    word_buf_nxt   = word_buf_r;
    pos_nxt        = pos_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    if (sts.out_free) out_valid_nxt = 1'b0;

    priority if (cmd.take) begin
      if (in_data.has_byte) begin
        byte_count_nxt = byte_count_r + COUNT_W'(1);
        if (pos_inc[2:0] == 3'd0) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.block_word  = {word_buf_r, in_data.data_byte};
          out_data_nxt.block_end   = byte_bend;
          out_data_nxt.message_end = 1'b0;
          word_buf_nxt             = '0;
          pos_nxt                  = byte_bend ? 7'd0 : pos_inc[6:0];
        end else begin
          word_buf_nxt = {word_buf_r[47:0], in_data.data_byte};
          pos_nxt      = pos_inc[6:0];
        end
      end
    end else if (cmd.pad_head || cmd.pad_zero || cmd.pad_len) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.block_end   = pad_bend;
      out_data_nxt.message_end = cmd.pad_len;
      word_buf_nxt             = '0;
      pos_nxt                  = pad_bend ? 7'd0 : word_end[6:0];
      if (cmd.pad_head) begin
        out_data_nxt.block_word = head_word;
      end else if (cmd.pad_len) begin
        out_data_nxt.block_word = len_big_endian ? bits_be : bits_le;
        byte_count_nxt          = '0;
        pos_nxt                 = 7'd0;
      end else begin
        out_data_nxt.block_word = '0;
      end
    end else begin
      // hold
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      word_buf_r   <= '0;
      pos_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      word_buf_r   <= word_buf_nxt;
      pos_r        <= pos_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/hash_message_padder.sv]
// Top level of the hash message padder: config registers, controller, datapath.
// Depends on hmp_pkg, hmp_ctrl, hmp_datapath.
//
//   channel   direction  handshake           payload
//   in_       input      in_valid/in_stall   in_item_t (byte, has_byte, eom)
//   out_      output     out_valid/out_stall out_item_t (64-bit word, flags)
//   cfg_      input      cfg_we              cfg_index, cfg_data
//
// One message byte per cycle while the output is not stalled; a finished word
// sits in the output register while the next byte is taken.
// End of message starts a burst of 2 to 17 padding words, one per cycle
// while the output is not stalled, with in_stall high; the single output register sets this pace.
// Synchronous active-low reset; config resets to 64-byte blocks, big-endian.
module hash_message_padder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  hmp_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output hmp_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [hmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hmp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hmp_pkg::*;

  logic       block_mode_r, len_big_endian_r;
  ctl_cmd_t   cmd;
  dp_status_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_mode_r     <= 1'b0;
      len_big_endian_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_MODE:     block_mode_r     <= cfg_data[0];
        CFG_LEN_BIG_ENDIAN: len_big_endian_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  hmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_eom   (in_data.end_of_message),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hmp_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .block_mode     (block_mode_r),
    .len_big_endian (len_big_endian_r),
    .in_data        (in_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule

[verif/hash_message_padder_tb.sv]
// Self-checking testbench for hash_message_padder: directed table, then random messages.
// Depends on hmp_pkg and the hash_message_padder RTL; the block's padding is modeled in-line.
module hash_message_padder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hmp_pkg::*;

  localparam int unsigned ITEM_TARGET = 360;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 24;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              item;
    bit                    has_tail;
    out_item_t             tail;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // padder model state
  logic [60:0] msg_bytes;
  logic [63:0] part_word;
  logic [7:0]  blk_pos;
  logic        mode_128;
  logic        len_be;
  out_item_t   pending_words[$];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  logic [31:0] stall_cyc = '0;
  logic [1:0]  stall_kind = '0;
  step_t       script[$];

  hash_message_padder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------- padding model ----------------
  task automatic shift_byte(input logic [7:0] b);
    logic [7:0] blk_size;
    out_item_t  w;
    blk_size = mode_128 ? 8'd128 : 8'd64;
    part_word = {part_word[55:0], b};
    blk_pos = blk_pos + 8'd1;
    if (blk_pos[2:0] == 3'd0) begin
      w.block_word = part_word;
      w.block_end = (blk_pos >= blk_size);
      w.message_end = 1'b0;
      pending_words.push_back(w);
      part_word = '0;
      if (blk_pos >= blk_size) blk_pos = '0;
    end
    blk_pos[7] = 1'b0;
  endtask

  task automatic pad_message();
    logic [7:0]  blk_size;
    logic [63:0] bit_len;
    out_item_t   w;
    blk_size = mode_128 ? 8'd128 : 8'd64;
    bit_len = {msg_bytes, 3'b000};
    shift_byte(PAD_MARKER);
    while (blk_pos != blk_size - 8'd8) shift_byte(8'h00);
    for (int i = 0; i < 8; i++) begin
      if (len_be) shift_byte(bit_len[63 - 8*i -: 8]);
      else shift_byte(bit_len[8*i +: 8]);
    end
    w = pending_words.pop_back();
    w.message_end = 1'b1;
    pending_words.push_back(w);
    msg_bytes = '0;
    part_word = '0;
    blk_pos = '0;
  endtask

  task automatic predict_item(input in_item_t it);
    if (it.has_byte) begin
      shift_byte(it.data_byte);
      msg_bytes = msg_bytes + 61'd1;
    end
    if (it.end_of_message) pad_message();
  endtask

  // ---------------- drivers ----------------
  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it);
    if (it.has_byte || it.end_of_message) items_sent++;
  endtask

  // Wait until every expected word is out and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BLOCK_MODE) mode_128 = val[0];
    else if (idx == CFG_LEN_BIG_ENDIAN) len_be = val[0];
  endtask

  task automatic run_message(input int len);
    int       k;
    int       mid_at;
    bit       eom_byte;
    in_item_t it;
    eom_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    mid_at = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, len)) : -1;
    for (k = 0; k < len - int'(eom_byte); k++) begin
      // block size switch in the middle of a message
      if (k == mid_at) begin
        settle();
        write_reg(CFG_BLOCK_MODE, CFG_DATA_W'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 7) == 0) begin
        it = '{data_byte: 8'($urandom), has_byte: 1'b0, end_of_message: 1'b0};
        send(it);
      end
      it = '{data_byte: 8'($urandom), has_byte: 1'b1, end_of_message: 1'b0};
      send(it);
    end
    it = '{data_byte: 8'($urandom), has_byte: eom_byte, end_of_message: 1'b1};
    send(it);
  endtask

  function automatic step_t byte_row(logic [7:0] d, logic h);
    step_t s;
    s = '{default: '0};
    s.item = '{data_byte: d, has_byte: h, end_of_message: 1'b0};
    return s;
  endfunction

  function automatic step_t end_row(logic [7:0] d, logic h, logic [63:0] len_word);
    step_t s;
    s = '{default: '0};
    s.item = '{data_byte: d, has_byte: h, end_of_message: 1'b1};
    s.has_tail = 1'b1;
    s.tail = '{block_word: len_word, block_end: 1'b1, message_end: 1'b1};
    return s;
  endfunction

  function automatic step_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  // ---------------- receiver stall pattern ----------------
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 32'd1;
    if (stall_cyc[5:0] == 6'd0) stall_kind <= 2'($urandom_range(0, 3));
    case (stall_kind)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 2) == 0);
      2'd2: out_stall <= (stall_cyc % 5 < 2);
      default: out_stall <= ($urandom_range(0, 2) != 0);
    endcase
  end

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word %h end=%b msg_end=%b", out_data.block_word,
                   out_data.block_end, out_data.message_end);
      end else begin
        want = pending_words.pop_front();
        if (out_data.block_word !== want.block_word || out_data.block_end !== want.block_end
            || out_data.message_end !== want.message_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: exp %h/%b/%b got %h/%b/%b", want.block_word,
                     want.block_end, want.message_end, out_data.block_word,
                     out_data.block_end, out_data.message_end);
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    int len;
    msg_bytes = '0;
    part_word = '0;
    blk_pos = '0;
    mode_128 = 1'b0;
    len_be = 1'b1;

    // empty message, 64-byte blocks, big-endian length
    script.push_back(end_row(8'h00, 1'b0, 64'd0));
    script.push_back(byte_row(8'hFF, 1'b1));
    script.push_back(byte_row(8'h00, 1'b1));
    script.push_back(byte_row(8'hFF, 1'b0));          // ignored byte
    script.push_back(end_row(8'h5A, 1'b1, 64'd24));
    script.push_back(cfg_row(CFG_LEN_BIG_ENDIAN, 1'b0));
    script.push_back(end_row(8'hFF, 1'b1, 64'h0800_0000_0000_0000));
    script.push_back(cfg_row(CFG_BLOCK_MODE, 1'b1));
    script.push_back(end_row(8'hA5, 1'b0, 64'd0));    // empty, 128-byte block
    script.push_back(cfg_row(CFG_LEN_BIG_ENDIAN, 1'b1));
    for (int i = 0; i < 4; i++) script.push_back(byte_row(8'(8'h11 * i), 1'b1));
    script.push_back(cfg_row(CFG_BLOCK_MODE, 1'b0));  // switch size mid-message
    for (int i = 0; i < 3; i++) script.push_back(byte_row(8'(8'hF0 + i), 1'b1));
    script.push_back(end_row(8'h80, 1'b1, 64'd64));
    script.push_back(byte_row(8'h00, 1'b0));
    script.push_back(end_row(8'h7F, 1'b1, 64'd8));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        send(script[i].item);
        if (script[i].has_tail) begin
          void'(pending_words.pop_back());
          pending_words.push_back(script[i].tail);
        end
      end
    end

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        if ($urandom_range(0, 1) == 1)
          write_reg(CFG_BLOCK_MODE, CFG_DATA_W'($urandom_range(0, 1)));
        else
          write_reg(CFG_LEN_BIG_ENDIAN, CFG_DATA_W'($urandom_range(0, 1)));
      end
      // favor lengths around the point where a second block is needed
      case ($urandom_range(0, 7))
        0, 1, 2: len = $urandom_range(0, 20);
        3:       len = $urandom_range(54, 58);
        4:       len = $urandom_range(62, 66);
        5:       len = $urandom_range(110, 122);
        6:       len = $urandom_range(126, 130);
        default: len = $urandom_range(0, 140);
      endcase
      run_message(len);
    end

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
